// ===== sv/sbra_pkg.sv =====
// Shared types and constants for the seat bitmap run allocator.
// Holds field widths, reset values, action codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package sbra_pkg;

    // Default geometry of the seat map
    localparam int DEF_MAX_ROWS  = 16;
    localparam int DEF_MAX_SEATS = 32;

    // Field widths
    localparam int ACTION_W   = 2;
    localparam int LETTER_W   = 8;
    localparam int SEAT_NUM_W = 8;
    localparam int RUN_W      = 6;
    localparam int FREE_W     = 10;
    localparam int ROWS_CFG_W = 5;
    localparam int SEATS_CFG_W = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Row letter of the first row
    localparam logic [LETTER_W-1:0] ROW_BASE = 8'd65;

    // Register reset values
    localparam logic [ROWS_CFG_W-1:0]  ROWS_RESET  = 5'd16;
    localparam logic [SEATS_CFG_W-1:0] SEATS_RESET = 6'd32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEATS_PER_ROW = 2'd1;

    // Action codes
    typedef enum logic [ACTION_W-1:0] {
        ACT_BOOK   = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

endpackage

// ===== sv/sbra_run_find.sv =====
// First-fit search for a run of free seats inside one row word.
// Depends on sbra_pkg for the default seat count and the run length width.
`timescale 1ns / 1ps

module sbra_run_find #(
    parameter int MAX_SEATS = sbra_pkg::DEF_MAX_SEATS,
    parameter int NS_W      = $clog2(MAX_SEATS + 1),
    parameter int SEAT_W    = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1
) (
    input  logic [MAX_SEATS-1:0]       word,
    input  logic [NS_W-1:0]            ns,
    input  logic [sbra_pkg::RUN_W-1:0] k,
    output logic                       hit,
    output logic [SEAT_W-1:0]          start,
    output logic [MAX_SEATS-1:0]       run_mask
);

    logic [MAX_SEATS-1:0] seat_mask;
    logic [MAX_SEATS-1:0] kmask;
    logic [MAX_SEATS-1:0] free_bits;

    // Seats in use and a window of k ones
    assign seat_mask = ~({MAX_SEATS{1'b1}} << ns);
    assign kmask     = ~({MAX_SEATS{1'b1}} << k);
    assign free_bits = ~word & seat_mask;

    // Check every start position, keep the lowest that fits
    always_comb
    begin
        logic [MAX_SEATS-1:0] win;
        hit   = 1'b0;
        start = '0;
        win   = '0;
        for (int s = MAX_SEATS - 1; s >= 0; s--)
        begin
            win = free_bits >> s;
            if (&(win | ~kmask))
            begin
                hit   = 1'b1;
                start = SEAT_W'(s);
            end
        end
    end

    assign run_mask = kmask << start;

endmodule

// ===== sv/seat_bitmap_run_allocator_unit.sv =====
// Seat bitmap run allocator: book, cancel and first-fit run booking.
// Flow: book and cancel read the addressed row and update it in ST_MOD; run-book scans rows
// from row 0 in ST_SCAN until a fit or the last row in use, then writes the hit row in ST_RUNWR;
// a bad address, unused action or bad run length skips both. Every word then sweeps the free count
// over all MAX_ROWS rows. One word at a time: the next is taken once the result is loaded.
// Reset: every seat free (per-row valid bits), registers at 16 rows, 32 seats.
`timescale 1ns / 1ps

module seat_bitmap_run_allocator_unit #(
    parameter int MAX_ROWS  = sbra_pkg::DEF_MAX_ROWS,
    parameter int MAX_SEATS = sbra_pkg::DEF_MAX_SEATS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // row_letter [7:0], seat_number [15:8], run_length [21:16], zero pad
    input  logic [sbra_pkg::IN_DATA_W-1:0]    s_tdata,
    // action [1:0]
    input  logic [sbra_pkg::ACTION_W-1:0]     s_tuser,
    // Result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // success [0], free_count [10:1], zero pad
    output logic [sbra_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                              cfg_we,
    input  logic [sbra_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sbra_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SEAT_W  = (MAX_SEATS > 1) ? $clog2(MAX_SEATS) : 1;
    localparam int NR_W    = $clog2(MAX_ROWS + 1);
    localparam int NS_W    = $clog2(MAX_SEATS + 1);
    localparam int POP_W   = $clog2(MAX_SEATS + 1);
    localparam int TAKEN_W = $clog2(MAX_ROWS * MAX_SEATS + 1);
    localparam int AREA_W  = (TAKEN_W > sbra_pkg::FREE_W) ? TAKEN_W : sbra_pkg::FREE_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_RUNWR,
        ST_COUNT,
        ST_DRAIN
    } state_t;

    state_t state_reg;

    // Configuration
    logic [sbra_pkg::ROWS_CFG_W-1:0]  rows_in_use_reg;
    logic [sbra_pkg::SEATS_CFG_W-1:0] seats_per_row_reg;
    logic [NR_W-1:0]                  nr;
    logic [NS_W-1:0]                  ns;
    logic [AREA_W-1:0]                area;
    logic [MAX_SEATS-1:0]             seat_mask;

    // Input fields
    sbra_pkg::action_t                in_action;
    logic [sbra_pkg::LETTER_W-1:0]    in_letter;
    logic [sbra_pkg::SEAT_NUM_W-1:0]  in_seat;
    logic [sbra_pkg::RUN_W-1:0]       in_run;
    logic [sbra_pkg::LETTER_W-1:0]    row_diff;
    logic [sbra_pkg::SEAT_NUM_W-1:0]  seat_m1;
    logic                             in_fire;
    logic                             loc_ok;
    logic                             run_ok;

    // Held item
    sbra_pkg::action_t                action_reg;
    logic [ROW_W-1:0]                 row_idx_reg;
    logic [SEAT_W-1:0]                bit_idx_reg;
    logic [sbra_pkg::RUN_W-1:0]       run_len_reg;
    logic                             ok_reg;

    // Memory and its port
    logic [MAX_SEATS-1:0]             seat_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0]              row_valid_reg;
    logic                             rd_en;
    logic [ROW_W-1:0]                 rd_addr;
    logic [MAX_SEATS-1:0]             rdata_reg;
    logic                             rd_row_valid_reg;
    logic                             wr_en;
    logic [ROW_W-1:0]                 wr_addr;
    logic [MAX_SEATS-1:0]             wr_data;
    logic [MAX_SEATS-1:0]             word;

    // Single-seat update
    logic [MAX_SEATS-1:0]             seat_onehot;
    logic                             seat_bit;
    logic                             mod_ok;
    logic [MAX_SEATS-1:0]             mod_word;

    // Run search
    logic [ROW_W-1:0]                 scan_row_reg;
    logic                             scan_last;
    logic                             hit;
    logic [SEAT_W-1:0]                start;
    logic [MAX_SEATS-1:0]             run_mask;
    logic [MAX_SEATS-1:0]             word_hold_reg;
    logic [MAX_SEATS-1:0]             run_mask_reg;

    // Free count sweep
    logic [ROW_W-1:0]                 cnt_row_reg;
    logic                             rd_cnt_vld_reg;
    logic [ROW_W-1:0]                 rd_tag_reg;
    logic                             pop_vld_reg;
    logic [POP_W-1:0]                 pop_reg;
    logic [TAKEN_W-1:0]               acc_reg;
    logic                             sweep_done;
    logic [AREA_W-1:0]                free_wide;

    // Output register
    logic                             out_load;
    logic                             out_valid_reg;
    logic                             out_success_reg;
    logic [sbra_pkg::FREE_W-1:0]      out_free_reg;

    // Effective geometry
    assign nr = (int'(rows_in_use_reg) < MAX_ROWS) ? NR_W'(rows_in_use_reg) : NR_W'(MAX_ROWS);
    assign ns = (int'(seats_per_row_reg) < MAX_SEATS) ? NS_W'(seats_per_row_reg)
                                                       : NS_W'(MAX_SEATS);
    assign area      = AREA_W'(nr) * AREA_W'(ns);
    assign seat_mask = ~({MAX_SEATS{1'b1}} << ns);

    // Unpack the input word and check its address
    assign in_action = sbra_pkg::action_t'(s_tuser);
    assign in_letter = s_tdata[7:0];
    assign in_seat   = s_tdata[15:8];
    assign in_run    = s_tdata[21:16];
    assign in_fire   = s_tvalid && s_tready;
    assign row_diff  = in_letter - sbra_pkg::ROW_BASE;
    assign seat_m1   = in_seat - 8'd1;
    assign loc_ok    = (in_letter >= sbra_pkg::ROW_BASE) && (row_diff < 8'(nr))
                       && (in_seat != 8'd0) && (in_seat <= 8'(ns));
    assign run_ok    = (in_run != '0) && (8'(in_run) <= 8'(ns)) && (nr != '0);

    assign s_tready = (state_reg == ST_IDLE);

    // Row word as read, invalid rows read free
    assign word = rd_row_valid_reg ? rdata_reg : '0;

    // Single-seat book or cancel
    assign seat_onehot = MAX_SEATS'(1) << bit_idx_reg;
    assign seat_bit    = |(word & seat_onehot);
    assign mod_ok      = (action_reg == sbra_pkg::ACT_BOOK) ? !seat_bit : seat_bit;
    assign mod_word    = (action_reg == sbra_pkg::ACT_BOOK) ? (word | seat_onehot)
                                                            : (word & ~seat_onehot);

    assign scan_last = (NR_W'(NR_W'(scan_row_reg) + NR_W'(1)) == nr);

    sbra_run_find #(
        .MAX_SEATS (MAX_SEATS),
        .NS_W      (NS_W),
        .SEAT_W    (SEAT_W)
    ) u_run_find (
        .word     (word),
        .ns       (ns),
        .k        (run_len_reg),
        .hit      (hit),
        .start    (start),
        .run_mask (run_mask)
    );

    // Read port select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((in_action == sbra_pkg::ACT_BOOK || in_action == sbra_pkg::ACT_CANCEL)
                        && loc_ok)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = row_diff[ROW_W-1:0];
                    end
                    else if (in_action == sbra_pkg::ACT_RUN && run_ok)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!hit && !scan_last)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ROW_W'(scan_row_reg + ROW_W'(1));
                end
            end
            ST_COUNT:
            begin
                rd_en   = 1'b1;
                rd_addr = cnt_row_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        unique case (state_reg)
            ST_MOD:
            begin
                wr_en   = mod_ok;
                wr_addr = row_idx_reg;
                wr_data = mod_word;
            end
            ST_RUNWR:
            begin
                wr_en   = 1'b1;
                wr_addr = scan_row_reg;
                wr_data = word_hold_reg | run_mask_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Seat map memory, one row word per entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seat_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= seat_mem[rd_addr];
        end
    end

    // Free count of the configured area
    assign sweep_done = !rd_cnt_vld_reg && !pop_vld_reg;
    assign free_wide  = area - AREA_W'(acc_reg);

    // Load the result register once the sweep is done and the slot is free
    assign out_load = (state_reg == ST_DRAIN) && sweep_done && (!out_valid_reg || m_tready);

    // Control, held item and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rows_in_use_reg   <= sbra_pkg::ROWS_RESET;
            seats_per_row_reg <= sbra_pkg::SEATS_RESET;
            row_valid_reg     <= '0;
            rd_row_valid_reg  <= 1'b0;
            rd_cnt_vld_reg    <= 1'b0;
            pop_vld_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
            action_reg        <= sbra_pkg::ACT_NONE;
            row_idx_reg       <= '0;
            bit_idx_reg       <= '0;
            run_len_reg       <= '0;
            ok_reg            <= 1'b0;
            scan_row_reg      <= '0;
            cnt_row_reg       <= '0;
            rd_tag_reg        <= '0;
            pop_reg           <= '0;
            acc_reg           <= '0;
            word_hold_reg     <= '0;
            run_mask_reg      <= '0;
            out_success_reg   <= 1'b0;
            out_free_reg      <= '0;
        end
        else
        begin
            // Register writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    sbra_pkg::CFG_ROWS_IN_USE:
                        rows_in_use_reg <= cfg_data[sbra_pkg::ROWS_CFG_W-1:0];
                    sbra_pkg::CFG_SEATS_PER_ROW:
                        seats_per_row_reg <= cfg_data[sbra_pkg::SEATS_CFG_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Track validity of the row being read
            if (rd_en)
            begin
                rd_row_valid_reg <= row_valid_reg[rd_addr];
            end

            // Count pipeline: read, popcount, accumulate
            rd_cnt_vld_reg <= (state_reg == ST_COUNT);
            rd_tag_reg     <= cnt_row_reg;
            pop_vld_reg    <= rd_cnt_vld_reg;
            if (rd_cnt_vld_reg)
            begin
                pop_reg <= (NR_W'(rd_tag_reg) < nr) ? POP_W'($countones(word & seat_mask))
                                                    : '0;
            end
            if (pop_vld_reg)
            begin
                acc_reg <= TAKEN_W'(acc_reg + TAKEN_W'(pop_reg));
            end

            // Set the result on load, drop it once taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        action_reg   <= in_action;
                        row_idx_reg  <= row_diff[ROW_W-1:0];
                        bit_idx_reg  <= seat_m1[SEAT_W-1:0];
                        run_len_reg  <= in_run;
                        ok_reg       <= 1'b0;
                        acc_reg      <= '0;
                        scan_row_reg <= '0;
                        cnt_row_reg  <= '0;
                        if ((in_action == sbra_pkg::ACT_BOOK
                             || in_action == sbra_pkg::ACT_CANCEL) && loc_ok)
                        begin
                            state_reg <= ST_MOD;
                        end
                        else if (in_action == sbra_pkg::ACT_RUN && run_ok)
                        begin
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_COUNT;
                        end
                    end
                end
                ST_MOD:
                begin
                    ok_reg <= mod_ok;
                    if (mod_ok)
                    begin
                        row_valid_reg[row_idx_reg] <= 1'b1;
                    end
                    state_reg <= ST_COUNT;
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        word_hold_reg <= word;
                        run_mask_reg  <= run_mask;
                        state_reg     <= ST_RUNWR;
                    end
                    else if (scan_last)
                    begin
                        state_reg <= ST_COUNT;
                    end
                    else
                    begin
                        scan_row_reg <= ROW_W'(scan_row_reg + ROW_W'(1));
                    end
                end
                ST_RUNWR:
                begin
                    ok_reg                      <= 1'b1;
                    row_valid_reg[scan_row_reg] <= 1'b1;
                    state_reg                   <= ST_COUNT;
                end
                ST_COUNT:
                begin
                    if (cnt_row_reg == ROW_W'(MAX_ROWS - 1))
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        cnt_row_reg <= ROW_W'(cnt_row_reg + ROW_W'(1));
                    end
                end
                ST_DRAIN:
                begin
                    if (out_load)
                    begin
                        out_success_reg <= ok_reg;
                        out_free_reg    <= free_wide[sbra_pkg::FREE_W-1:0];
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sbra_pkg::OUT_DATA_W - sbra_pkg::FREE_W - 1){1'b0}},
                       out_free_reg, out_success_reg};

    // Never read and write the same row in one cycle
    a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write collide on one row");

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while busy");

    // A found run lies inside the seats in use
    a_run_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && hit)
        |-> ((8'(start) + 8'(run_len_reg)) <= 8'(ns)))
        else $error("run found beyond row end");

    // Taken count never exceeds the area
    a_taken_in_area: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && sweep_done) |-> (AREA_W'(acc_reg) <= area))
        else $error("taken count above area");

endmodule

// ===== tb/seat_bitmap_run_allocator_unit_tb.sv =====
// Self-checking testbench for seat_bitmap_run_allocator_unit: book, cancel and run-book
// words checked against a seat map predictor kept in a scoreboard class.
// Depends on sbra_pkg and the seat_bitmap_run_allocator_unit RTL.
`timescale 1ns / 1ps

module seat_bitmap_run_allocator_unit_tb;
    import sbra_pkg::*;

    localparam int ROWS = DEF_MAX_ROWS;
    localparam int SEATS = DEF_MAX_SEATS;
    localparam int DRAIN_CYCLES = 3 * ROWS + 12;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              success;
        logic [FREE_W-1:0] free_count;
    } seat_result_t;

    // Seat map predictor and the queue of results it expects
    class seat_map_scoreboard;
        logic [SEATS-1:0]       seat_map [ROWS];
        logic [ROWS_CFG_W-1:0]  rows_reg;
        logic [SEATS_CFG_W-1:0] seats_reg;
        seat_result_t           expected_q [$];
        int                     mismatches;

        function new();
            foreach (seat_map[r])
                seat_map[r] = '0;
            rows_reg = ROWS_RESET;
            seats_reg = SEATS_RESET;
            mismatches = 0;
        endfunction

        function int rows_used();
            return (rows_reg < ROWS) ? int'(rows_reg) : ROWS;
        endfunction

        function int seats_used();
            return (seats_reg < SEATS) ? int'(seats_reg) : SEATS;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ROWS_IN_USE:   rows_reg = val[ROWS_CFG_W-1:0];
                CFG_SEATS_PER_ROW: seats_reg = val[SEATS_CFG_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_area(int row, int pos);
            return row >= 0 && row < rows_used() && pos >= 0 && pos < seats_used();
        endfunction

        // Take the earliest run of k free seats in the first row that has one
        function bit claim_run(int k);
            int ns;
            int run;
            ns = seats_used();
            if (k == 0 || k > ns)
                return 1'b0;
            for (int r = 0; r < rows_used(); r++)
            begin
                run = 0;
                for (int s = 0; s < ns; s++)
                begin
                    if (seat_map[r][s])
                    begin
                        run = 0;
                    end
                    else
                    begin
                        run++;
                        if (run == k)
                        begin
                            for (int t = s - k + 1; t <= s; t++)
                                seat_map[r][t] = 1'b1;
                            return 1'b1;
                        end
                    end
                end
            end
            return 1'b0;
        endfunction

        // Apply one accepted word and queue the result it must produce
        function void note_request(action_t act, logic [LETTER_W-1:0] ltr,
                                   logic [SEAT_NUM_W-1:0] seat, logic [RUN_W-1:0] k);
            int row;
            int pos;
            int taken;
            bit ok;
            seat_result_t res;
            row = int'(ltr) - int'(ROW_BASE);
            pos = int'(seat) - 1;
            ok = 1'b0;
            case (act)
                ACT_BOOK:
                    if (in_area(row, pos) && !seat_map[row][pos])
                    begin
                        seat_map[row][pos] = 1'b1;
                        ok = 1'b1;
                    end
                ACT_CANCEL:
                    if (in_area(row, pos) && seat_map[row][pos])
                    begin
                        seat_map[row][pos] = 1'b0;
                        ok = 1'b1;
                    end
                ACT_RUN:
                    ok = claim_run(int'(k));
                default:
                    ok = 1'b0;
            endcase
            taken = 0;
            for (int r = 0; r < rows_used(); r++)
                for (int s = 0; s < seats_used(); s++)
                    if (seat_map[r][s])
                        taken++;
            res.success = ok;
            res.free_count = FREE_W'(rows_used() * seats_used() - taken);
            expected_q.push_back(res);
        endfunction

        // Compare one result word with the oldest expectation
        function void check_result(logic [OUT_DATA_W-1:0] data);
            seat_result_t exp_res;
            logic              got_success;
            logic [FREE_W-1:0] got_free;
            got_success = data[0];
            got_free = data[FREE_W:1];
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result word success=%0b free=%0d",
                             $realtime, got_success, got_free);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got_success !== exp_res.success || got_free !== exp_res.free_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result mismatch: expected success=%0b free=%0d, ",
                              "got success=%0b free=%0d"},
                             $realtime, exp_res.success, exp_res.free_count,
                             got_success, got_free);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [ACTION_W-1:0] s_tuser = ACT_NONE;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS_IN_USE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;

    seat_map_scoreboard sb = new();

    // Phase table: register values, idling mode and word count
    int phase_rows [9] = '{16, 1, 31, 0, 4, 16, 3, 0, 16};
    int phase_seats [9] = '{32, 1, 63, 7, 8, 0, 5, 0, 32};
    int phase_mode [9] = '{0, 1, 2, 3, 0, 1, 2, 3, 0};
    int phase_words [9] = '{80, 70, 80, 30, 80, 30, 80, 100, 80};

    seat_bitmap_run_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Check accepted result words, then pick the next ready level
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hold one request word until accepted, with random idle cycles ahead of it
    task automatic send_word(input action_t act, input logic [LETTER_W-1:0] ltr,
                             input logic [SEAT_NUM_W-1:0] seat, input logic [RUN_W-1:0] k);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, k, seat, ltr};
        s_tuser <= act;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(act, ltr, seat, k);
    endtask

    // Draw one random word, mostly well formed for the current geometry
    task automatic random_word();
        int nr;
        int ns;
        int pick;
        action_t act;
        logic [LETTER_W-1:0] ltr;
        logic [SEAT_NUM_W-1:0] seat;
        logic [RUN_W-1:0] k;
        nr = sb.rows_used();
        ns = sb.seats_used();
        pick = $urandom_range(99);
        act = action_t'($urandom_range(3));
        ltr = LETTER_W'($urandom);
        seat = SEAT_NUM_W'($urandom);
        k = RUN_W'($urandom);
        if (nr > 0 && ns > 0 && pick >= 15)
        begin
            pick = $urandom_range(99);
            act = (pick < 45) ? ACT_BOOK : (pick < 72) ? ACT_CANCEL : ACT_RUN;
            ltr = LETTER_W'(int'(ROW_BASE) + int'($urandom_range(nr - 1)));
            seat = SEAT_NUM_W'($urandom_range(ns, 1));
            if ($urandom_range(3) == 0)
                k = RUN_W'($urandom_range(ns, 1));
            else
                k = RUN_W'($urandom_range((ns < 4) ? ns : 4, 1));
            // Step just past the configured area now and then
            if ($urandom_range(19) == 0)
            begin
                ltr = LETTER_W'(int'(ROW_BASE) + nr);
                seat = SEAT_NUM_W'(ns + 1);
                k = RUN_W'(ns + 1);
            end
        end
        send_word(act, ltr, seat, k);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int rows_val;
        int seats_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words on the reset geometry
        send_word(ACT_BOOK, ROW_BASE, 8'd1, 6'd0);
        send_word(ACT_BOOK, ROW_BASE, 8'd1, 6'd0);          // seat already taken
        send_word(ACT_CANCEL, ROW_BASE, 8'd1, 6'd0);
        send_word(ACT_CANCEL, ROW_BASE, 8'd1, 6'd0);        // seat already free
        send_word(ACT_BOOK, ROW_BASE - 8'd1, 8'd1, 6'd0);   // letter below the first row
        send_word(ACT_BOOK, ROW_BASE + 8'd15, 8'd32, 6'd0); // last row, last seat
        send_word(ACT_BOOK, ROW_BASE + 8'd16, 8'd1, 6'd0);  // row past the area
        send_word(ACT_BOOK, 8'hFF, 8'hFF, 6'h3F);
        send_word(ACT_CANCEL, 8'h00, 8'h00, 6'h00);
        send_word(ACT_BOOK, ROW_BASE, 8'd0, 6'd0);          // seat zero
        send_word(ACT_BOOK, ROW_BASE, 8'd33, 6'd0);         // seat past the row
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd0);             // empty run
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd33);            // run longer than a row
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd63);
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd32);            // whole first row
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd1);
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd31);            // rest of the second row
        send_word(ACT_NONE, ROW_BASE, 8'd2, 6'd2);
        send_word(ACT_CANCEL, ROW_BASE + 8'd1, 8'd1, 6'd0); // one-seat hole
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd2);             // must skip the hole
        send_word(ACT_RUN, 8'h00, 8'h00, 6'd1);             // fills the hole
        send_word(ACT_CANCEL, ROW_BASE + 8'd15, 8'd32, 6'd0);
        s_tvalid <= 1'b0;

        // Random phases over several geometries and idling modes
        for (int p = 0; p < 9; p++)
        begin
            wait_idle();
            rows_val = phase_rows[p];
            seats_val = phase_seats[p];
            if (p == 7)
            begin
                rows_val = $urandom_range(63, 1);
                seats_val = $urandom_range(63, 1);
            end
            cfg_write(CFG_ROWS_IN_USE, CFG_DATA_W'(rows_val));
            cfg_write(CFG_SEATS_PER_ROW, CFG_DATA_W'(seats_val));
            if (p % 3 == 1)
                cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
            cfg_we <= 1'b0;
            @(posedge clk);
            case (phase_mode[p])
                1:
                begin
                    idle_pct = 68;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 68;
                end
                3:
                begin
                    idle_pct = 8;
                    stall_pct = 8;
                end
                default:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
            endcase
            for (int i = 0; i < phase_words[p]; i++)
                random_word();
            s_tvalid <= 1'b0;
        end

        // Drain, then watch for stray words
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Hard stop if the handshakes hang
    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
